@@ design/mpp_pkg.sv @@
package mpp_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DUP_SCAN,
    ST_STORE,
    ST_FL_RD,
    ST_FL_MUL,
    ST_FL_CMP,
    ST_EMIT_L,
    ST_SEL_SCAN,
    ST_SEL_EMIT,
    ST_EMIT_R
  } mpp_state_t;

  // Control of the point store and the side flag store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic flag_wr_en;
    logic flag_wr_data;
  } mpp_mem_ctl_t;

endpackage

@@ design/mpp_if.sv @@
interface mpp_in_if #(
  parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink (input valid, point_x, point_y, final_point, output ready);
endinterface

interface mpp_out_if #(
  parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         final_vertex;
  logic                         overflowed;

  modport source (output valid, vertex_x, vertex_y, final_vertex, overflowed, input ready);
  modport sink (input valid, vertex_x, vertex_y, final_vertex, overflowed, output ready);
endinterface

@@ design/mpp_store.sv @@
module mpp_store #(
  parameter int MAX_POINTS = mpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int DAT_W = 2 * COORD_BITS
) (
  input  logic                 clk,
  input  mpp_pkg::mpp_mem_ctl_t ctl,
  input  logic [IDX_W-1:0]     rd_addr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [DAT_W-1:0]     wr_data,
  output logic [DAT_W-1:0]     rd_data_r,
  output logic                 rd_flag_r
);
  import mpp_pkg::*;

  // Points as {x, y}; side flags share the read address.
  logic [DAT_W-1:0] pts_mem [MAX_POINTS];
  logic             flag_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      pts_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= pts_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.flag_wr_en) begin
      flag_mem[wr_addr] <= ctl.flag_wr_data;
    end
    if (ctl.rd_en) begin
      rd_flag_r <= flag_mem[rd_addr];
    end
  end

endmodule

@@ design/mpp_ctrl.sv @@
module mpp_ctrl #(
  parameter int MAX_POINTS = mpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS),
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int DAT_W = 2 * COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_final,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_final,
  output logic                         out_ovf,
  output mpp_pkg::mpp_mem_ctl_t        ctl,
  output logic [IDX_W-1:0]             rd_addr,
  output logic [IDX_W-1:0]             wr_addr,
  output logic [DAT_W-1:0]             wr_data,
  input  logic [DAT_W-1:0]             rd_data,
  input  logic                         rd_flag
);
  import mpp_pkg::*;

  localparam int D_W = COORD_BITS + 1;
  localparam int P_W = 2 * D_W;

  mpp_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] lm_r, lm_nxt, rm_r, rm_nxt;
  logic signed [COORD_BITS-1:0] lx_r, lx_nxt, ly_r, ly_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic ovf_r, ovf_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic fin_r, fin_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic sv_r, sv_nxt;
  logic [IDX_W-1:0] si_r, si_nxt;
  logic [CNT_W-1:0] n_up_r, n_up_nxt, k_r, k_nxt;
  logic lower_r, lower_nxt;
  logic prev_v_r, prev_v_nxt, best_v_r, best_v_nxt;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_x_nxt, best_x_r, best_x_nxt;
  logic signed [COORD_BITS-1:0] best_y_r, best_y_nxt;
  logic [IDX_W-1:0] prev_i_r, prev_i_nxt, best_i_r, best_i_nxt;
  logic signed [P_W-1:0] prod_l_r, prod_l_nxt, prod_r_r, prod_r_nxt;
  logic out_valid_r, out_valid_nxt, out_final_r, out_final_nxt, out_ovf_r, out_ovf_nxt;
  logic signed [COORD_BITS-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic signed [COORD_BITS-1:0] cx, cy;
  logic [IDX_W-1:0] ci;
  logic signed [D_W-1:0] d_bx, d_by, d_px, d_py;
  logic slot_free, emit_fire, emit_last, dup_hit, scan_end, more_to_read;
  logic cand_ok, up_flag, up_more;

  assign cx = rd_data[DAT_W-1:COORD_BITS];
  assign cy = rd_data[COORD_BITS-1:0];
  assign ci = si_r;
  assign d_bx = D_W'(rx_r) - D_W'(lx_r);
  assign d_by = D_W'(ry_r) - D_W'(ly_r);
  assign d_px = D_W'(cx) - D_W'(lx_r);
  assign d_py = D_W'(cy) - D_W'(ly_r);

  assign slot_free = !out_valid_r || out_ready;
  assign emit_fire = slot_free &&
                     (state_r == ST_EMIT_L || state_r == ST_EMIT_R || state_r == ST_SEL_EMIT);
  assign emit_last = (k_r + CNT_W'(1)) == count_r;
  assign dup_hit = sv_r && (rd_data == {px_r, py_r});
  assign more_to_read = i_r < count_r;
  assign scan_end = !more_to_read && !sv_r;
  assign up_flag = (ci != lm_r) && (ci != rm_r) && (prod_l_r > prod_r_r);
  assign up_more = n_up_r != CNT_W'(1);

  // A stored entry is a candidate when it sits on the current chain, comes after
  // the vertex last emitted in chain order and beats the best seen in this pass.
  always_comb begin
    logic qual, after, better;
    qual = lower_r ? (!rd_flag && ci != lm_r && ci != rm_r) : rd_flag;
    after = !prev_v_r || (lower_r ? (cx < prev_x_r) : (cx > prev_x_r)) ||
            (cx == prev_x_r && ci > prev_i_r);
    better = !best_v_r || (lower_r ? (cx > best_x_r) : (cx < best_x_r));
    cand_ok = sv_r && qual && after && better;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DUP_SCAN;
        end
      end
      ST_DUP_SCAN: begin
        if (dup_hit) begin
          state_nxt = fin_r ? ST_FL_RD : ST_IDLE;
        end else if (scan_end) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: state_nxt = fin_r ? ST_FL_RD : ST_IDLE;
      ST_FL_RD: state_nxt = ST_FL_MUL;
      ST_FL_MUL: state_nxt = ST_FL_CMP;
      ST_FL_CMP: begin
        state_nxt = ((i_r + CNT_W'(1)) == count_r) ? ST_EMIT_L : ST_FL_RD;
      end
      ST_EMIT_L: begin
        if (slot_free) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else if (n_up_r != '0 || lm_r == rm_r) begin
            state_nxt = ST_SEL_SCAN;
          end else begin
            state_nxt = ST_EMIT_R;
          end
        end
      end
      ST_SEL_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_SEL_EMIT;
        end
      end
      ST_SEL_EMIT: begin
        if (slot_free) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else if (lower_r || up_more || lm_r == rm_r) begin
            state_nxt = ST_SEL_SCAN;
          end else begin
            state_nxt = ST_EMIT_R;
          end
        end
      end
      ST_EMIT_R: begin
        if (slot_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_SEL_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;  lm_nxt = lm_r;  rm_nxt = rm_r;
    lx_nxt = lx_r;  ly_nxt = ly_r;  rx_nxt = rx_r;  ry_nxt = ry_r;
    ovf_nxt = ovf_r;  px_nxt = px_r;  py_nxt = py_r;  fin_nxt = fin_r;
    i_nxt = i_r;  sv_nxt = 1'b0;  si_nxt = si_r;
    n_up_nxt = n_up_r;  k_nxt = k_r;  lower_nxt = lower_r;
    prev_v_nxt = prev_v_r;  prev_x_nxt = prev_x_r;  prev_i_nxt = prev_i_r;
    best_v_nxt = best_v_r;  best_x_nxt = best_x_r;  best_y_nxt = best_y_r;
    best_i_nxt = best_i_r;
    prod_l_nxt = prod_l_r;  prod_r_nxt = prod_r_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt = out_x_r;  out_y_nxt = out_y_r;
    out_final_nxt = out_final_r;  out_ovf_nxt = out_ovf_r;
    ctl = '0;
    rd_addr = i_r[IDX_W-1:0];
    wr_addr = count_r[IDX_W-1:0];
    wr_data = {px_r, py_r};

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          px_nxt = in_x;  py_nxt = in_y;  fin_nxt = in_final;
          i_nxt = '0;
        end
      end
      ST_DUP_SCAN, ST_SEL_SCAN: begin
        if (state_r == ST_SEL_SCAN && cand_ok) begin
          best_v_nxt = 1'b1;  best_x_nxt = cx;  best_y_nxt = cy;  best_i_nxt = ci;
        end
        if (more_to_read && !(state_r == ST_DUP_SCAN && dup_hit)) begin
          ctl.rd_en = 1'b1;
          sv_nxt = 1'b1;
          si_nxt = i_r[IDX_W-1:0];
          i_nxt = i_r + CNT_W'(1);
        end
        if (state_r == ST_DUP_SCAN && dup_hit) begin
          i_nxt = '0;  n_up_nxt = '0;
        end
      end
      ST_STORE: begin
        if (count_r == CNT_W'(MAX_POINTS)) begin
          ovf_nxt = 1'b1;
        end else begin
          ctl.wr_en = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0) begin
            lm_nxt = '0;  rm_nxt = '0;
            lx_nxt = px_r;  ly_nxt = py_r;  rx_nxt = px_r;  ry_nxt = py_r;
          end else begin
            if (px_r < lx_r) begin
              lm_nxt = count_r[IDX_W-1:0];  lx_nxt = px_r;  ly_nxt = py_r;
            end
            if (px_r > rx_r) begin
              rm_nxt = count_r[IDX_W-1:0];  rx_nxt = px_r;  ry_nxt = py_r;
            end
          end
        end
        i_nxt = '0;  n_up_nxt = '0;
      end
      ST_FL_RD: begin
        ctl.rd_en = 1'b1;
        si_nxt = i_r[IDX_W-1:0];
      end
      ST_FL_MUL: begin
        prod_l_nxt = d_bx * d_py;
        prod_r_nxt = d_by * d_px;
      end
      ST_FL_CMP: begin
        wr_addr = si_r;
        ctl.flag_wr_en = 1'b1;
        ctl.flag_wr_data = up_flag;
        n_up_nxt = n_up_r + CNT_W'(up_flag);
        i_nxt = i_r + CNT_W'(1);
        k_nxt = '0;
      end
      default: ;
    endcase

    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_final_nxt = emit_last;
      out_ovf_nxt = ovf_r;
      k_nxt = k_r + CNT_W'(1);
      i_nxt = '0;
      best_v_nxt = 1'b0;
      case (state_r)
        ST_EMIT_L: begin
          out_x_nxt = lx_r;  out_y_nxt = ly_r;
          prev_v_nxt = 1'b0;
          lower_nxt = (n_up_r == '0);
        end
        ST_EMIT_R: begin
          out_x_nxt = rx_r;  out_y_nxt = ry_r;
          prev_v_nxt = 1'b0;
          lower_nxt = 1'b1;
        end
        default: begin
          out_x_nxt = best_x_r;  out_y_nxt = best_y_r;
          prev_v_nxt = 1'b1;  prev_x_nxt = best_x_r;  prev_i_nxt = best_i_r;
          if (!lower_r) begin
            n_up_nxt = n_up_r - CNT_W'(1);
            if (!up_more) begin
              prev_v_nxt = 1'b0;
              lower_nxt = 1'b1;
            end
          end
        end
      endcase
      if (emit_last) begin
        count_nxt = '0;  lm_nxt = '0;  rm_nxt = '0;  ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      lm_r <= '0;
      rm_r <= '0;
      ovf_r <= 1'b0;
      sv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      lm_r <= lm_nxt;
      rm_r <= rm_nxt;
      ovf_r <= ovf_nxt;
      sv_r <= sv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lx_r <= lx_nxt;  ly_r <= ly_nxt;  rx_r <= rx_nxt;  ry_r <= ry_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;  fin_r <= fin_nxt;
    i_r <= i_nxt;  si_r <= si_nxt;  n_up_r <= n_up_nxt;  k_r <= k_nxt;
    lower_r <= lower_nxt;
    prev_v_r <= prev_v_nxt;  prev_x_r <= prev_x_nxt;  prev_i_r <= prev_i_nxt;
    best_v_r <= best_v_nxt;  best_x_r <= best_x_nxt;  best_y_r <= best_y_nxt;
    best_i_r <= best_i_nxt;
    prod_l_r <= prod_l_nxt;  prod_r_r <= prod_r_nxt;
    out_x_r <= out_x_nxt;  out_y_r <= out_y_nxt;
    out_final_r <= out_final_nxt;  out_ovf_r <= out_ovf_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_final = out_final_r;
  assign out_ovf = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_extremes_stored: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> (CNT_W'(lm_r) < count_r) && (CNT_W'(rm_r) < count_r))
    else $error("extreme index outside stored points");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && emit_last |=> count_r == '0 && !ovf_r)
    else $error("set not cleared after last vertex");

  a_scan_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEL_EMIT |-> best_v_r)
    else $error("chain scan ended without a vertex");

endmodule

@@ design/monotone_polygon_from_points_unit.sv @@
// Builds an x-monotone simple polygon from a set of integer points.
// Input channel in_ch: one point per request (point_x, point_y, final_point).
// Each point is compared against the stored points for exact duplicates, one
// store read per cycle, until a match or the end of the set; only then is
// the next request taken. Duplicates are dropped, points beyond MAX_POINTS are
// dropped and flag the set as overflowed.
// The request with final_point set starts the polygon pass: a side test of
// each point (store read, two registered cross products, compare), then the
// leftmost and rightmost points directly and every other vertex by its own
// selection scan of the store, one vertex per scan, in chain order.
// Output channel out_ch: one vertex per request, final_vertex on the last one,
// overflowed on every vertex of an overflowed set. The vertex sits in an output
// register; when the receiver stalls, the polygon pass simply waits on it.
// A synchronous reset (rst_n low) empties the set; the point store itself is
// not cleared, since only entries written in the current set are ever read.
module monotone_polygon_from_points_unit #(
  parameter int MAX_POINTS = mpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = mpp_pkg::COORD_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  mpp_in_if.sink  in_ch,
  mpp_out_if.source out_ch
);
  import mpp_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int DAT_W = 2 * COORD_BITS;

  mpp_mem_ctl_t     mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [DAT_W-1:0] wr_data;
  logic [DAT_W-1:0] rd_data;
  logic             rd_flag;

  // Sequencer: duplicate check, extreme tracking, side test and chain ordering.
  mpp_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_x      (in_ch.point_x),
    .in_y      (in_ch.point_y),
    .in_final  (in_ch.final_point),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.vertex_x),
    .out_y     (out_ch.vertex_y),
    .out_final (out_ch.final_vertex),
    .out_ovf   (out_ch.overflowed),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .rd_flag   (rd_flag)
  );

  // Point store and upper-chain flags, one registered read port.
  mpp_store #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_r (rd_data),
    .rd_flag_r (rd_flag)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mpp_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int CB = COORD_BITS_DEF;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic final_point;
  } point_req_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic final_vertex;
    logic overflowed;
  } vertex_t;

  logic clk;
  logic rst_n;

  mpp_in_if #(.COORD_BITS(CB)) in_ch ();
  mpp_out_if #(.COORD_BITS(CB)) out_ch ();

  monotone_polygon_from_points_unit #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Pending point requests, and the vertices the polygon model expects.
  point_req_t pending_points[$];
  vertex_t expected_vertices[$];

  // Model copy of the set that is being loaded.
  logic signed [CB-1:0] set_x[NPTS];
  logic signed [CB-1:0] set_y[NPTS];
  int set_count = 0;
  int left_idx = 0;
  int right_idx = 0;
  bit set_overflow = 1'b0;

  int mismatches = 0;
  int vertices_seen = 0;
  int polygons_seen = 0;
  longint cycle_count = 0;
  bit quiet_mode;       // no idling on either side near the end
  bit hold_sender;      // sender waits for every expected vertex

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sort a list of store indices by x, keeping arrival order among equal x.
  function automatic void order_by_x(ref int idx[$], input bit ascending);
    int key;
    int j;
    for (int i = 1; i < idx.size(); i++) begin
      key = idx[i];
      j = i;
      while (j > 0 && (ascending ? (set_x[idx[j-1]] > set_x[key])
                                 : (set_x[idx[j-1]] < set_x[key]))) begin
        idx[j] = idx[j-1];
        j--;
      end
      idx[j] = key;
    end
  endfunction

  // Load one point into the model set; on the last point, build the polygon.
  function automatic void polygon_model_step(point_req_t p);
    bit dup;
    int upper[$];
    int lower[$];
    int order[$];
    longint lhs;
    longint rhs;
    vertex_t v;
    dup = 1'b0;
    for (int i = 0; i < set_count; i++)
      if (set_x[i] == p.x && set_y[i] == p.y) dup = 1'b1;
    if (!dup) begin
      if (set_count >= NPTS) begin
        set_overflow = 1'b1;
      end else begin
        set_x[set_count] = p.x;
        set_y[set_count] = p.y;
        if (set_count == 0) begin
          left_idx = 0;
          right_idx = 0;
        end else begin
          if (p.x < set_x[left_idx]) left_idx = set_count;
          if (p.x > set_x[right_idx]) right_idx = set_count;
        end
        set_count++;
      end
    end
    if (!p.final_point) return;

    // Upper chain is strictly left of the line from leftmost to rightmost.
    for (int i = 0; i < set_count; i++) begin
      if (i == left_idx || i == right_idx) continue;
      lhs = (longint'(set_x[right_idx]) - set_x[left_idx]) *
            (longint'(set_y[i]) - set_y[left_idx]);
      rhs = (longint'(set_y[right_idx]) - set_y[left_idx]) *
            (longint'(set_x[i]) - set_x[left_idx]);
      if (lhs > rhs) upper = {upper, i};
      else lower = {lower, i};
    end
    order_by_x(upper, 1'b1);
    order_by_x(lower, 1'b0);
    order = {order, left_idx};
    foreach (upper[i]) order = {order, upper[i]};
    if (right_idx != left_idx) order = {order, right_idx};
    foreach (lower[i]) order = {order, lower[i]};
    foreach (order[i]) begin
      v.x = set_x[order[i]];
      v.y = set_y[order[i]];
      v.final_vertex = (i == order.size() - 1);
      v.overflowed = set_overflow;
      expected_vertices = {expected_vertices, v};
    end
    set_count = 0;
    left_idx = 0;
    right_idx = 0;
    set_overflow = 1'b0;
  endfunction

  // Set at the rising edge that takes a request.
  bit req_taken;

  // Driver: presents queued requests, changing inputs at the falling edge.
  int send_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && !req_taken) begin
      // Hold the request until it is taken.
    end else if (send_gap > 0) begin
      in_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_points.size() > 0 && !hold_sender) begin
      in_ch.valid <= 1'b1;
      in_ch.point_x <= pending_points[0].x;
      in_ch.point_y <= pending_points[0].y;
      in_ch.final_point <= pending_points[0].final_point;
      if (!quiet_mode && $urandom_range(0, 5) == 0)
        send_gap <= $urandom_range(1, 10);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Acceptance of a request feeds the model at the rising edge.
  always @(posedge clk) begin
    req_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      polygon_model_step(pending_points.pop_front());
    end
  end

  // Receiver stalls come in bursts as well.
  int stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compares each vertex with the oldest expectation.
  vertex_t want;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      vertices_seen++;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex (%0d,%0d) final=%0b ovf=%0b",
                   out_ch.vertex_x, out_ch.vertex_y, out_ch.final_vertex,
                   out_ch.overflowed);
      end else begin
        want = expected_vertices.pop_front();
        if (want.final_vertex) polygons_seen++;
        if (out_ch.vertex_x !== want.x || out_ch.vertex_y !== want.y ||
            out_ch.final_vertex !== want.final_vertex ||
            out_ch.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"vertex mismatch: expected (%0d,%0d) f=%0b o=%0b, ",
                      "got (%0d,%0d) f=%0b o=%0b"},
                     want.x, want.y, want.final_vertex, want.overflowed,
                     out_ch.vertex_x, out_ch.vertex_y, out_ch.final_vertex,
                     out_ch.overflowed);
        end
      end
    end
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL monotone_polygon_from_points_unit");
      $finish;
    end
  end

  task automatic add_point(int x, int y, bit last);
    point_req_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.final_point = last;
    pending_points = {pending_points, p};
  endtask

  // A random set of n points; coordinates are often drawn from a narrow range
  // so that duplicates, equal x and collinear points show up.
  task automatic add_random_set(int n);
    int span;
    span = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if (span == 32767)
        add_point($signed(16'($urandom)), $signed(16'($urandom)), i == n - 1);
      else
        add_point($urandom_range(0, 2 * span) - span,
                  $urandom_range(0, 2 * span) - span, i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || expected_vertices.size() > 0)
      @(posedge clk);
  endtask

  int random_items;
  int n;
  initial begin
    rst_n = 1'b0;
    quiet_mode = 1'b0;
    hold_sender = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sets. A lone point, then coordinate extremes with a duplicate.
    add_point(5, -7, 1'b1);
    add_point(-32768, 32767, 1'b0);
    add_point(32767, -32768, 1'b0);
    add_point(-32768, 32767, 1'b0);
    add_point(0, 32767, 1'b0);
    add_point(0, -32768, 1'b1);
    // Single distinct x: the lower chain keeps arrival order.
    add_point(3, 9, 1'b0);
    add_point(3, -2, 1'b0);
    add_point(3, 4, 1'b1);
    // Collinear points, equal x in a chain, and a duplicate as the last point.
    add_point(0, 0, 1'b0);
    add_point(4, 4, 1'b0);
    add_point(2, 2, 1'b0);
    add_point(2, 7, 1'b0);
    add_point(2, 5, 1'b0);
    add_point(4, 4, 1'b1);

    // Once every directed point is sent, the sender pauses with the next set
    // queued until every vertex has come.
    while (pending_points.size() > 0)
      @(posedge clk);
    hold_sender = 1'b1;

    // An overflowing set; its final point is dropped for lack of room.
    for (int i = 0; i < NPTS + 3; i++)
      add_point(i * 37 - 600, (i * 91) % 500 - 250, i == NPTS + 2);
    while (expected_vertices.size() > 0)
      @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    random_items = 0;
    while (random_items < 220) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(NPTS - 2, NPTS + 4);
      else n = $urandom_range(1, 10);
      if (random_items > 180) quiet_mode = 1'b1;
      add_random_set(n);
      random_items += n;
      wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Checked %0d vertices of %0d polygons, from directed sets and random sets",
             vertices_seen, polygons_seen);
    $display("with duplicates, equal x, collinear points and overflow; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("PASS monotone_polygon_from_points_unit");
    end else begin
      $display("FAIL monotone_polygon_from_points_unit");
    end
    $finish;
  end
endmodule

@@ monotone_polygon_from_points_unit.f @@
design/mpp_pkg.sv
design/mpp_if.sv
design/mpp_store.sv
design/mpp_ctrl.sv
design/monotone_polygon_from_points_unit.sv
verif/testbench.sv
